### rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types, constants and helpers for the box collision resolve block.
// ----------------------------------------------------------------------------
package acr_pkg;

   // Field widths.
   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 14;
   localparam int SIDE_BITS  = 4;
   localparam int MOTION_BITS = 4;
   localparam int REFLECT_BITS = 2;

   // Internal arithmetic width: holds any edge coordinate and any depth.
   localparam int MAX_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int EXT_BITS = MAX_BITS + 3;

   // Side indexes, same bit order as the side masks.
   localparam int SIDE_LEFT   = 0;
   localparam int SIDE_RIGHT  = 1;
   localparam int SIDE_TOP    = 2;
   localparam int SIDE_BOTTOM = 3;

   // Motion bits and the side masks that each of them applies.
   localparam int MOTION_X_TRUE  = 0;
   localparam int MOTION_X_FALSE = 1;
   localparam int MOTION_Y_TRUE  = 2;
   localparam int MOTION_Y_FALSE = 3;
   localparam logic [SIDE_BITS-1:0] MASK_NO_LEFT   = 4'd14;
   localparam logic [SIDE_BITS-1:0] MASK_NO_RIGHT  = 4'd13;
   localparam logic [SIDE_BITS-1:0] MASK_NO_TOP    = 4'd11;
   localparam logic [SIDE_BITS-1:0] MASK_NO_BOTTOM = 4'd7;

   // Reflect mask bits.
   localparam int REFLECT_H = 0;
   localparam int REFLECT_V = 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [SIZE_BITS-1:0]  size_type;
   typedef logic signed [EXT_BITS-1:0]   ext_type;
   typedef logic        [SIDE_BITS-1:0]  side_type;

   // Saturation limits in the wide format.
   localparam ext_type COORD_MAX_EXT = ext_type'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam ext_type COORD_MIN_EXT = ext_type'(-(64'sd1 <<< (COORD_BITS - 1)));

   // One request as held in the input register.
   typedef struct packed {
      coord_type                ball_x;
      coord_type                ball_y;
      size_type                 ball_w;
      size_type                 ball_h;
      coord_type                obs_x;
      coord_type                obs_y;
      size_type                 obs_w;
      size_type                 obs_h;
      logic [MOTION_BITS-1:0]   motion_flags;
      side_type                 allowed_sides;
      logic [REFLECT_BITS-1:0]  reflect_mask;
   } req_type;

   // One result as held in the output register.
   typedef struct packed {
      coord_type  new_x;
      coord_type  new_y;
      side_type   popped_sides;
      logic       reflect_x;
      logic       reflect_y;
   } rsp_type;

   // Side selection handed from the selector to the push-out logic.
   typedef struct packed {
      side_type   popped;
   } sel_type;

   // Sign-extend a coordinate into the wide format.
   function automatic ext_type ext_coord(input coord_type v);
      return ext_type'(v);
   endfunction

   // Zero-extend a size into the wide format.
   function automatic ext_type ext_size(input size_type v);
      ext_type r;
      r = '0;
      r[SIZE_BITS-1:0] = v;
      return r;
   endfunction

   // Clamp a wide value to the coordinate range.
   function automatic coord_type sat_coord(input ext_type v);
      ext_type r;
      if (v > COORD_MAX_EXT) begin
         r = COORD_MAX_EXT;
      end else if (v < COORD_MIN_EXT) begin
         r = COORD_MIN_EXT;
      end else begin
         r = v;
      end
      return coord_type'(r[COORD_BITS-1:0]);
   endfunction

endpackage

### rtl/acr_side_select.sv
// ----------------------------------------------------------------------------
// acr_side_select
// Finds the intersected sides and picks the shallowest allowed side plus
// the first other allowed side that ties with it.
// ----------------------------------------------------------------------------
module acr_side_select
   import acr_pkg::*;
(
   input  req_type  req,
   output sel_type  sel
);

   ext_type  bx, by, br, bb;
   ext_type  ox, oy, orr, ob;
   ext_type  depth [SIDE_BITS];
   ext_type  best_depth;
   side_type allow;
   side_type hit;
   side_type cand;
   side_type best;
   side_type tie;
   side_type second;
   logic     overlap;

   // Box edges in the wide format, extents are closed.
   always_comb begin
      bx  = ext_coord(req.ball_x);
      by  = ext_coord(req.ball_y);
      ox  = ext_coord(req.obs_x);
      oy  = ext_coord(req.obs_y);
      br  = bx + ext_size(req.ball_w) - ext_type'(1);
      bb  = by + ext_size(req.ball_h) - ext_type'(1);
      orr = ox + ext_size(req.obs_w) - ext_type'(1);
      ob  = oy + ext_size(req.obs_h) - ext_type'(1);
   end

   // Motion flags knock sides out of the allowed mask.
   always_comb begin
      allow = req.allowed_sides;
      if (req.motion_flags[MOTION_X_TRUE]) begin
         allow = allow & MASK_NO_LEFT;
      end
      if (req.motion_flags[MOTION_X_FALSE]) begin
         allow = allow & MASK_NO_RIGHT;
      end
      if (req.motion_flags[MOTION_Y_TRUE]) begin
         allow = allow & MASK_NO_TOP;
      end
      if (req.motion_flags[MOTION_Y_FALSE]) begin
         allow = allow & MASK_NO_BOTTOM;
      end
   end

   // Overlap test, intersected sides and penetration depths.
   always_comb begin
      overlap = (bx <= br) && (ox <= orr) && (bx <= orr) && (ox <= br) &&
                (by <= bb) && (oy <= ob) && (by <= ob) && (oy <= bb);
      hit[SIDE_LEFT]   = overlap && (bx <= ox) && (ox <= br);
      hit[SIDE_RIGHT]  = overlap && (bx <= orr) && (orr <= br);
      hit[SIDE_TOP]    = overlap && (by <= oy) && (oy <= bb);
      hit[SIDE_BOTTOM] = overlap && (by <= ob) && (ob <= bb);
      depth[SIDE_LEFT]   = br - ox + ext_type'(1);
      depth[SIDE_RIGHT]  = orr - bx + ext_type'(1);
      depth[SIDE_TOP]    = bb - oy + ext_type'(1);
      depth[SIDE_BOTTOM] = ob - by + ext_type'(1);
      cand = hit & allow;
   end

   // Shallowest candidate; an earlier side wins a tie.
   always_comb begin
      for (int i = 0; i < SIDE_BITS; i++) begin
         best[i] = cand[i];
         for (int j = 0; j < SIDE_BITS; j++) begin
            if (j < i) begin
               if (cand[j] && !(depth[i] < depth[j])) begin
                  best[i] = 1'b0;
               end
            end else if (j > i) begin
               if (cand[j] && !(depth[i] <= depth[j])) begin
                  best[i] = 1'b0;
               end
            end
         end
      end
   end

   // First other candidate with the same depth as the winner.
   always_comb begin
      best_depth = '0;
      for (int i = 0; i < SIDE_BITS; i++) begin
         if (best[i]) begin
            best_depth = depth[i];
         end
      end
      for (int i = 0; i < SIDE_BITS; i++) begin
         tie[i] = cand[i] && !best[i] && (depth[i] == best_depth);
      end
      second = tie & (~tie + side_type'(1));
      sel.popped = best | second;
   end

endmodule

### rtl/acr_push_out.sv
// ----------------------------------------------------------------------------
// acr_push_out
// Moves the box out along the first popped side and forms the reflect flags.
// ----------------------------------------------------------------------------
module acr_push_out
   import acr_pkg::*;
(
   input  req_type  req,
   input  sel_type  sel,
   output rsp_type  rsp
);

   ext_type nx;
   ext_type ny;

   // Moving out along a side puts the box flush against that edge.
   always_comb begin
      nx = ext_coord(req.ball_x);
      ny = ext_coord(req.ball_y);
      if (sel.popped[SIDE_LEFT]) begin
         nx = ext_coord(req.obs_x) - ext_size(req.ball_w);
      end else if (sel.popped[SIDE_RIGHT]) begin
         nx = ext_coord(req.obs_x) + ext_size(req.obs_w);
      end else if (sel.popped[SIDE_TOP]) begin
         ny = ext_coord(req.obs_y) - ext_size(req.ball_h);
      end else if (sel.popped[SIDE_BOTTOM]) begin
         ny = ext_coord(req.obs_y) + ext_size(req.obs_h);
      end
   end

   // Saturated position and reflect flags.
   always_comb begin
      rsp.new_x        = sat_coord(nx);
      rsp.new_y        = sat_coord(ny);
      rsp.popped_sides = sel.popped;
      rsp.reflect_x    = (sel.popped[SIDE_LEFT] || sel.popped[SIDE_RIGHT]) &&
                         req.reflect_mask[REFLECT_H];
      rsp.reflect_y    = (sel.popped[SIDE_TOP] || sel.popped[SIDE_BOTTOM]) &&
                         req.reflect_mask[REFLECT_V];
   end

endmodule

### rtl/aabb_collision_resolve.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolve
// Box against box collision with minimum-penetration push-out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Content
//  req_*     in         req_valid/req_stall  moving box, fixed box, flags, masks
//  rsp_*     out        rsp_valid/rsp_stall  new position, popped sides, reflects
//
//  A request is held in the input register and then moves to the
//  result register, whose contents drive the rsp_* ports.
//  One request is accepted per cycle while the response side is not stalled;
//  the single compare-and-select pass between the two registers sets that figure.
//  Reset clears both stage valid bits; no payload is cleared.
//  A stalled response holds the result register, and the input register
//  keeps taking a request until both stages are full.
// ----------------------------------------------------------------------------
module aabb_collision_resolve
   import acr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  coord_type                req_ball_x,
   input  coord_type                req_ball_y,
   input  size_type                 req_ball_w,
   input  size_type                 req_ball_h,
   input  coord_type                req_obs_x,
   input  coord_type                req_obs_y,
   input  size_type                 req_obs_w,
   input  size_type                 req_obs_h,
   input  logic [MOTION_BITS-1:0]   req_motion_flags,
   input  side_type                 req_allowed_sides,
   input  logic [REFLECT_BITS-1:0]  req_reflect_mask,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output coord_type                rsp_new_x,
   output coord_type                rsp_new_y,
   output side_type                 rsp_popped_sides,
   output logic                     rsp_reflect_x,
   output logic                     rsp_reflect_y
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_rsp_ff, s2_rsp_in;
   logic    s1_ready;
   logic    s2_ready;
   req_type req_now;
   sel_type sel;
   rsp_type rsp_now;

   // Gather the request ports.
   always_comb begin
      req_now.ball_x        = req_ball_x;
      req_now.ball_y        = req_ball_y;
      req_now.ball_w        = req_ball_w;
      req_now.ball_h        = req_ball_h;
      req_now.obs_x         = req_obs_x;
      req_now.obs_y         = req_obs_y;
      req_now.obs_w         = req_obs_w;
      req_now.obs_h         = req_obs_h;
      req_now.motion_flags  = req_motion_flags;
      req_now.allowed_sides = req_allowed_sides;
      req_now.reflect_mask  = req_reflect_mask;
   end

   // Compute the response from the input register.
   acr_side_select u_side_select (
      .req (s1_req_ff),
      .sel (sel)
   );

   acr_push_out u_push_out (
      .req (s1_req_ff),
      .sel (sel),
      .rsp (rsp_now)
   );

   // Stage flow control.
   always_comb begin
      s2_ready  = !s2_valid_ff || !rsp_stall;
      s1_ready  = !s1_valid_ff || s2_ready;
      req_stall = !s1_ready;

      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
         s1_req_in   = req_now;
      end

      s2_valid_in = s2_valid_ff;
      s2_rsp_in   = s2_rsp_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_rsp_in   = rsp_now;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      s2_rsp_ff <= s2_rsp_in;
   end

   // Response ports.
   assign rsp_valid        = s2_valid_ff;
   assign rsp_new_x        = s2_rsp_ff.new_x;
   assign rsp_new_y        = s2_rsp_ff.new_y;
   assign rsp_popped_sides = s2_rsp_ff.popped_sides;
   assign rsp_reflect_x    = s2_rsp_ff.reflect_x;
   assign rsp_reflect_y    = s2_rsp_ff.reflect_y;

   // At most the winner and one tying side are popped.
   a_popped_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(rsp_popped_sides) <= 2))
      else $error("more than two sides popped");

   // A horizontal reflect needs a popped left or right side.
   a_reflect_x : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reflect_x) |->
         (rsp_popped_sides[SIDE_LEFT] || rsp_popped_sides[SIDE_RIGHT]))
      else $error("horizontal reflect without a horizontal side");

   // A vertical reflect needs a popped top or bottom side.
   a_reflect_y : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reflect_y) |->
         (rsp_popped_sides[SIDE_TOP] || rsp_popped_sides[SIDE_BOTTOM]))
      else $error("vertical reflect without a vertical side");

   // A held request moves to the result register when the output is free.
   a_advance : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_stall) |=> rsp_valid)
      else $error("request did not advance to the result register");

   // The input side stalls only when both stages are occupied.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff))
      else $error("request stalled with a free stage");

endmodule

### bench/aabb_collision_resolve_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_collision_resolve_checker
// Watches both channels of the box collision block, predicts the push-out
// for every accepted request and compares each response field by field.
// ----------------------------------------------------------------------------
module aabb_collision_resolve_checker
   import acr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   input  logic                     req_stall,
   input  coord_type                req_ball_x,
   input  coord_type                req_ball_y,
   input  size_type                 req_ball_w,
   input  size_type                 req_ball_h,
   input  coord_type                req_obs_x,
   input  coord_type                req_obs_y,
   input  size_type                 req_obs_w,
   input  size_type                 req_obs_h,
   input  logic [MOTION_BITS-1:0]   req_motion_flags,
   input  side_type                 req_allowed_sides,
   input  logic [REFLECT_BITS-1:0]  req_reflect_mask,

   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  coord_type                rsp_new_x,
   input  coord_type                rsp_new_y,
   input  side_type                 rsp_popped_sides,
   input  logic                     rsp_reflect_x,
   input  logic                     rsp_reflect_y,

   output int                       mismatch_count,
   output int                       pending_moves
);

   localparam int COORD_HI = (1 <<< (COORD_BITS - 1)) - 1;
   localparam int COORD_LO = -COORD_HI - 1;

   // Predicted responses, oldest first.
   rsp_type predicted_moves[$];

   // Clamp an unbounded position to the coordinate range.
   function automatic coord_type clamp_coord(input int v);
      int c;
      c = v;
      if (c > COORD_HI) begin
         c = COORD_HI;
      end else if (c < COORD_LO) begin
         c = COORD_LO;
      end
      return coord_type'(c);
   endfunction

   // Minimum-penetration push-out of the moving box out of the fixed box.
   function automatic rsp_type resolve_push_out(input req_type r);
      int        b_left, b_top, b_right, b_bottom;
      int        o_left, o_top, o_right, o_bottom;
      int        depth [4];
      bit [3:0]  hit;
      side_type  usable;
      side_type  popped;
      int        best, tie, nx, ny, i;
      rsp_type   res;

      b_left   = r.ball_x;
      b_top    = r.ball_y;
      b_right  = b_left + int'(r.ball_w) - 1;
      b_bottom = b_top + int'(r.ball_h) - 1;
      o_left   = r.obs_x;
      o_top    = r.obs_y;
      o_right  = o_left + int'(r.obs_w) - 1;
      o_bottom = o_top + int'(r.obs_h) - 1;

      // Each motion flag rules out one side.
      usable = r.allowed_sides;
      if (r.motion_flags[MOTION_X_TRUE])  usable &= MASK_NO_LEFT;
      if (r.motion_flags[MOTION_X_FALSE]) usable &= MASK_NO_RIGHT;
      if (r.motion_flags[MOTION_Y_TRUE])  usable &= MASK_NO_TOP;
      if (r.motion_flags[MOTION_Y_FALSE]) usable &= MASK_NO_BOTTOM;

      // Sides of the fixed box that lie inside the moving box, with depths.
      hit = '0;
      for (i = 0; i < 4; i++) depth[i] = 0;
      if (((b_left > o_left) ? b_left : o_left) <= ((b_right < o_right) ? b_right : o_right) &&
          ((b_top > o_top) ? b_top : o_top) <= ((b_bottom < o_bottom) ? b_bottom : o_bottom)) begin
         hit[SIDE_LEFT]     = (o_left >= b_left) && (o_left <= b_right);
         hit[SIDE_RIGHT]    = (o_right >= b_left) && (o_right <= b_right);
         hit[SIDE_TOP]      = (o_top >= b_top) && (o_top <= b_bottom);
         hit[SIDE_BOTTOM]   = (o_bottom >= b_top) && (o_bottom <= b_bottom);
         depth[SIDE_LEFT]   = b_right - o_left + 1;
         depth[SIDE_RIGHT]  = o_right - b_left + 1;
         depth[SIDE_TOP]    = b_bottom - o_top + 1;
         depth[SIDE_BOTTOM] = o_bottom - b_top + 1;
      end

      // Shallowest usable side, then the first other one at the same depth.
      best = -1;
      for (i = 0; i < 4; i++) begin
         if (hit[i] && usable[i]) begin
            if (best < 0) begin
               best = i;
            end else if (depth[i] < depth[best]) begin
               best = i;
            end
         end
      end
      tie = -1;
      popped = '0;
      if (best >= 0) begin
         for (i = 0; i < 4; i++) begin
            if (tie < 0 && i != best && hit[i] && usable[i] && depth[i] == depth[best]) begin
               tie = i;
            end
         end
         popped[best] = 1'b1;
         if (tie >= 0) popped[tie] = 1'b1;
      end

      // The box moves along one popped side only.
      nx = b_left;
      ny = b_top;
      if (popped[SIDE_LEFT]) begin
         nx = b_left - depth[SIDE_LEFT];
      end else if (popped[SIDE_RIGHT]) begin
         nx = b_left + depth[SIDE_RIGHT];
      end else if (popped[SIDE_TOP]) begin
         ny = b_top - depth[SIDE_TOP];
      end else if (popped[SIDE_BOTTOM]) begin
         ny = b_top + depth[SIDE_BOTTOM];
      end

      res.new_x        = clamp_coord(nx);
      res.new_y        = clamp_coord(ny);
      res.popped_sides = popped;
      res.reflect_x    = (popped[SIDE_LEFT] | popped[SIDE_RIGHT]) & r.reflect_mask[REFLECT_H];
      res.reflect_y    = (popped[SIDE_TOP] | popped[SIDE_BOTTOM]) & r.reflect_mask[REFLECT_V];
      return res;
   endfunction

   task automatic flag_field(input string field, input int want_v, input int got_v);
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatch_count++;
   endtask

   // Compare each accepted response, then record the prediction for each
   // accepted request.
   always @(posedge clock) begin
      req_type seen_req;
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_moves.size() == 0) begin
               $display("%0t: response with none expected: expected none, actual x %0d y %0d",
                        $time, rsp_new_x, rsp_new_y);
               mismatch_count++;
            end else begin
               want = predicted_moves.pop_front();
               if (rsp_new_x !== want.new_x) flag_field("new_x", want.new_x, rsp_new_x);
               if (rsp_new_y !== want.new_y) flag_field("new_y", want.new_y, rsp_new_y);
               if (rsp_popped_sides !== want.popped_sides) begin
                  flag_field("popped_sides", want.popped_sides, rsp_popped_sides);
               end
               if (rsp_reflect_x !== want.reflect_x) begin
                  flag_field("reflect_x", want.reflect_x, rsp_reflect_x);
               end
               if (rsp_reflect_y !== want.reflect_y) begin
                  flag_field("reflect_y", want.reflect_y, rsp_reflect_y);
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen_req.ball_x        = req_ball_x;
            seen_req.ball_y        = req_ball_y;
            seen_req.ball_w        = req_ball_w;
            seen_req.ball_h        = req_ball_h;
            seen_req.obs_x         = req_obs_x;
            seen_req.obs_y         = req_obs_y;
            seen_req.obs_w         = req_obs_w;
            seen_req.obs_h         = req_obs_h;
            seen_req.motion_flags  = req_motion_flags;
            seen_req.allowed_sides = req_allowed_sides;
            seen_req.reflect_mask  = req_reflect_mask;
            predicted_moves.push_back(resolve_push_out(seen_req));
         end
         pending_moves = predicted_moves.size();
      end
   end

endmodule

### bench/aabb_collision_resolve_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_collision_resolve_tb
// Drives directed and random box pairs into the collision block with random
// gaps on the request side and random stalls on the response side; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module aabb_collision_resolve_tb;
   import acr_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   localparam int ALL_SIDES    = 15;
   localparam int NO_SIDES     = 0;
   localparam int NO_MOTION    = 0;
   localparam int ALL_MOTION   = 15;
   localparam int NO_REFLECT   = 0;
   localparam int BOTH_REFLECT = (1 << REFLECT_H) | (1 << REFLECT_V);
   localparam int SIZE_MAX     = (1 << SIZE_BITS) - 1;
   localparam int COORD_HI     = (1 <<< (COORD_BITS - 1)) - 1;
   localparam int COORD_LO     = -COORD_HI - 1;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_bus;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   coord_type  rsp_new_x;
   coord_type  rsp_new_y;
   side_type   rsp_popped_sides;
   logic       rsp_reflect_x;
   logic       rsp_reflect_y;
   int         mismatch_count;
   int         pending_moves;
   int         cycle_count = 0;
   int         stall_run = 0;
   int         stall_calm = 0;
   int         send_calm = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aabb_collision_resolve u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ball_x        (req_bus.ball_x),
      .req_ball_y        (req_bus.ball_y),
      .req_ball_w        (req_bus.ball_w),
      .req_ball_h        (req_bus.ball_h),
      .req_obs_x         (req_bus.obs_x),
      .req_obs_y         (req_bus.obs_y),
      .req_obs_w         (req_bus.obs_w),
      .req_obs_h         (req_bus.obs_h),
      .req_motion_flags  (req_bus.motion_flags),
      .req_allowed_sides (req_bus.allowed_sides),
      .req_reflect_mask  (req_bus.reflect_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_new_x         (rsp_new_x),
      .rsp_new_y         (rsp_new_y),
      .rsp_popped_sides  (rsp_popped_sides),
      .rsp_reflect_x     (rsp_reflect_x),
      .rsp_reflect_y     (rsp_reflect_y)
   );

   aabb_collision_resolve_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ball_x        (req_bus.ball_x),
      .req_ball_y        (req_bus.ball_y),
      .req_ball_w        (req_bus.ball_w),
      .req_ball_h        (req_bus.ball_h),
      .req_obs_x         (req_bus.obs_x),
      .req_obs_y         (req_bus.obs_y),
      .req_obs_w         (req_bus.obs_w),
      .req_obs_h         (req_bus.obs_h),
      .req_motion_flags  (req_bus.motion_flags),
      .req_allowed_sides (req_bus.allowed_sides),
      .req_reflect_mask  (req_bus.reflect_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_new_x         (rsp_new_x),
      .rsp_new_y         (rsp_new_y),
      .rsp_popped_sides  (rsp_popped_sides),
      .rsp_reflect_x     (rsp_reflect_x),
      .rsp_reflect_y     (rsp_reflect_y),
      .mismatch_count    (mismatch_count),
      .pending_moves     (pending_moves)
   );

   // Idle lengths: mostly short ones, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(9) == 0) begin
         return $urandom_range(40, 10);
      end
      return $urandom_range(3, 1);
   endfunction

   // Box sizes: mostly tiny so that equal depths are common.
   function automatic int pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return $urandom_range(12, 1);
      end else if (roll < 90) begin
         return $urandom_range(300, 1);
      end
      return $urandom_range(SIZE_MAX, 1);
   endfunction

   function automatic req_type box_pair(input int bx, input int by, input int bw, input int bh,
                                        input int ox, input int oy, input int ow, input int oh,
                                        input int motion, input int allow, input int refl);
      req_type r;
      r.ball_x        = coord_type'(bx);
      r.ball_y        = coord_type'(by);
      r.ball_w        = size_type'(bw);
      r.ball_h        = size_type'(bh);
      r.obs_x         = coord_type'(ox);
      r.obs_y         = coord_type'(oy);
      r.obs_w         = size_type'(ow);
      r.obs_h         = size_type'(oh);
      r.motion_flags  = MOTION_BITS'(motion);
      r.allowed_sides = side_type'(allow);
      r.reflect_mask  = REFLECT_BITS'(refl);
      return r;
   endfunction

   // Random request: mostly overlapping pairs, some touching pairs, some noise.
   function automatic req_type random_request();
      int kind, bx, by, bw, bh, ox, oy, ow, oh, motion, allow;
      kind   = $urandom_range(99);
      motion = ($urandom_range(2) == 0) ? $urandom_range(ALL_MOTION) : NO_MOTION;
      allow  = ($urandom_range(3) == 0) ? ALL_SIDES : $urandom_range(ALL_SIDES);
      if (kind < 15) begin
         // Any field value, zero sizes included.
         return box_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      bw = pick_size();
      bh = pick_size();
      ow = pick_size();
      oh = pick_size();
      // Place the fixed box; now and then close to the ends of the range.
      if ($urandom_range(6) == 0) begin
         ox = ($urandom_range(1) == 0) ? COORD_LO + $urandom_range(40) : COORD_HI - $urandom_range(40);
         oy = ($urandom_range(1) == 0) ? COORD_LO + $urandom_range(40) : COORD_HI - $urandom_range(40);
      end else begin
         ox = $urandom_range(COORD_HI - COORD_LO) + COORD_LO;
         oy = $urandom_range(COORD_HI - COORD_LO) + COORD_LO;
      end
      bx = ox + $urandom_range(bw + ow - 2) - (bw - 1);
      by = oy + $urandom_range(bh + oh - 2) - (bh - 1);
      // Touching pairs share an edge line without overlapping.
      if (kind < 25) begin
         if ($urandom_range(1) == 0) begin
            bx = ($urandom_range(1) == 0) ? ox + ow : ox - bw;
         end else begin
            by = ($urandom_range(1) == 0) ? oy + oh : oy - bh;
         end
      end
      return box_pair(bx, by, bw, bh, ox, oy, ow, oh, motion, allow, $urandom_range(BOTH_REFLECT));
   endfunction

   // Present one request and hold it until it is accepted.
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_bus   <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Send, then maybe leave a gap; calm stretches keep the channel full.
   task automatic send_with_idling(input req_type r);
      send_request(r);
      if (send_calm > 0) begin
         send_calm--;
      end else if ($urandom_range(99) < 30) begin
         idle_sender(pick_gap());
      end else if ($urandom_range(99) < 2) begin
         send_calm = $urandom_range(150, 50);
      end
   endtask

   // Response side back-pressure with the same gap profile.
   always @(posedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm > 0) begin
            stall_calm <= stall_calm - 1;
         end else if ($urandom_range(99) < 25) begin
            stall_run <= pick_gap();
         end else if ($urandom_range(99) < 3) begin
            stall_calm <= $urandom_range(200, 40);
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aabb_collision_resolve_tb failed");
         $finish;
      end
   end

   initial begin
      int n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_bus   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Separate boxes, then boxes that touch without overlapping.
      send_with_idling(box_pair(0, 0, 10, 10, 100, 100, 10, 10, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 10, 10, 10, 0, 10, 10, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      // Corner overlap where left and top tie, with and without usable sides.
      send_with_idling(box_pair(0, 0, 10, 10, 9, 9, 10, 10, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 10, 10, 9, 9, 10, 10, 1 << MOTION_X_TRUE, ALL_SIDES,
                                BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 10, 10, 9, 9, 10, 10, 1 << MOTION_Y_TRUE, ALL_SIDES,
                                BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 10, 10, 9, 9, 10, 10, NO_MOTION, NO_SIDES, BOTH_REFLECT));
      // One side at a time against a fixed box.
      send_with_idling(box_pair(90, 105, 15, 5, 100, 100, 20, 20, NO_MOTION, ALL_SIDES,
                                1 << REFLECT_H));
      send_with_idling(box_pair(115, 105, 15, 5, 100, 100, 20, 20, NO_MOTION, ALL_SIDES,
                                1 << REFLECT_V));
      send_with_idling(box_pair(105, 90, 5, 15, 100, 100, 20, 20, NO_MOTION, ALL_SIDES,
                                1 << REFLECT_V));
      send_with_idling(box_pair(105, 115, 5, 15, 100, 100, 20, 20, NO_MOTION, ALL_SIDES,
                                NO_REFLECT));
      send_with_idling(box_pair(105, 115, 5, 15, 100, 100, 20, 20, 1 << MOTION_Y_FALSE, ALL_SIDES,
                                BOTH_REFLECT));
      // Fixed box inside the moving box: all four sides hit.
      send_with_idling(box_pair(0, 0, 50, 50, 10, 20, 5, 5, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 50, 50, 10, 20, 5, 5, ALL_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 50, 50, 10, 20, 5, 5, 1 << MOTION_X_FALSE, ALL_SIDES,
                                BOTH_REFLECT));
      // Empty extents never overlap.
      send_with_idling(box_pair(0, 0, 0, 10, 0, 0, 10, 10, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(0, 0, 10, 10, 0, 0, 10, 0, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      // Largest boxes and saturation at each end of both axes.
      send_with_idling(box_pair(COORD_LO, COORD_LO, SIZE_MAX, SIZE_MAX, -20000, -20000,
                                SIZE_MAX, SIZE_MAX, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(COORD_HI, COORD_HI, SIZE_MAX, SIZE_MAX, COORD_HI, COORD_HI,
                                SIZE_MAX, SIZE_MAX, NO_MOTION, ALL_SIDES, BOTH_REFLECT));
      send_with_idling(box_pair(COORD_LO, 0, 10, 10, COORD_LO + 3, 0, 20, 10, NO_MOTION,
                                1 << SIDE_LEFT, BOTH_REFLECT));
      send_with_idling(box_pair(COORD_HI - 5, 0, 10, 10, 32700, 0, 70, 10, NO_MOTION,
                                1 << SIDE_RIGHT, BOTH_REFLECT));
      send_with_idling(box_pair(0, COORD_LO, 10, 10, 0, COORD_LO + 3, 10, 20, NO_MOTION,
                                1 << SIDE_TOP, BOTH_REFLECT));
      send_with_idling(box_pair(0, COORD_HI - 5, 10, 10, 0, 32700, 10, 70, NO_MOTION,
                                1 << SIDE_BOTTOM, BOTH_REFLECT));

      // Random requests, with one full drain halfway through.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_moves != 0);
         end
         send_with_idling(random_request());
      end
      req_valid <= 1'b0;

      // Wait for the last responses, then a few more cycles for strays.
      do @(posedge clock); while (pending_moves != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_moves == 0) begin
         $display("aabb_collision_resolve_tb passed");
      end else begin
         $display("aabb_collision_resolve_tb failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/acr_pkg.sv
rtl/acr_side_select.sv
rtl/acr_push_out.sv
rtl/aabb_collision_resolve.sv
bench/aabb_collision_resolve_checker.sv
bench/aabb_collision_resolve_tb.sv
